@@ src/vn_pkg.sv @@
package vn_pkg;

    localparam int COMP_W     = 16;
    localparam int UNIT_FRAC  = 14;
    localparam int UNIT_W     = 16;
    localparam int SQ_W       = 32;
    localparam int LEN_W      = 16;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = UNIT_FRAC + 1;
    localparam int REM_W      = LEN_W + 1;
    localparam int LANES      = 3;

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } in_item_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic [SQ_W-1:0]          length_sq;
        logic [LEN_W-1:0]         length_val;
        logic                     zero_len;
    } out_item_t;

    // per-item data that rides along the square root pipeline
    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [LANES-1:0]             neg;
        logic [SQ_W-1:0]              sq;
    } side_t;

endpackage

@@ src/vn_sqrt.sv @@
module vn_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  vn_pkg::side_t                  in_side,
    output logic                           out_valid,
    output vn_pkg::side_t                  out_side,
    output logic [vn_pkg::LEN_W-1:0]       out_len
);

    logic                      v    [0:vn_pkg::SQRT_STEPS];
    vn_pkg::side_t             side [0:vn_pkg::SQRT_STEPS];
    logic [vn_pkg::SQ_W-1:0]   n    [0:vn_pkg::SQRT_STEPS];
    logic [vn_pkg::SQ_W-1:0]   res  [0:vn_pkg::SQRT_STEPS];

    assign v[0]    = in_valid;
    assign side[0] = in_side;
    assign n[0]    = in_side.sq;
    assign res[0]  = '0;

    // one result bit per stage, highest bit first
    for (genvar k = 0; k < vn_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [vn_pkg::SQ_W-1:0] BITV =
            vn_pkg::SQ_W'(1) << (vn_pkg::SQ_W - 2 - 2 * k);

        logic                    v_reg;
        vn_pkg::side_t           side_reg;
        logic [vn_pkg::SQ_W-1:0] n_reg, n_next;
        logic [vn_pkg::SQ_W-1:0] res_reg, res_next;
        logic [vn_pkg::SQ_W:0]   trial;

        always_comb begin
            trial = {1'b0, res[k]} + {1'b0, BITV};
            if ({1'b0, n[k]} >= trial) begin
                n_next   = n[k] - trial[vn_pkg::SQ_W-1:0];
                res_next = (res[k] >> 1) + BITV;
            end else begin
                n_next   = n[k];
                res_next = res[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg <= side[k];
                n_reg    <= n_next;
                res_reg  <= res_next;
            end
        end

        assign v[k+1]    = v_reg;
        assign side[k+1] = side_reg;
        assign n[k+1]    = n_reg;
        assign res[k+1]  = res_reg;
    end

    assign out_valid = v[vn_pkg::SQRT_STEPS];
    assign out_side  = side[vn_pkg::SQRT_STEPS];
    assign out_len   = res[vn_pkg::SQRT_STEPS][vn_pkg::LEN_W-1:0];

endmodule

@@ src/vn_div.sv @@
module vn_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  vn_pkg::side_t             in_side,
    input  logic [vn_pkg::LEN_W-1:0]  in_len,
    output logic                      out_valid,
    output vn_pkg::out_item_t         out_item
);

    typedef logic [vn_pkg::LANES-1:0][vn_pkg::REM_W-1:0]  rem_vec_t;
    typedef logic [vn_pkg::LANES-1:0][vn_pkg::UNIT_W-1:0] quo_vec_t;

    logic                      v    [0:vn_pkg::DIV_STEPS];
    vn_pkg::side_t             side [0:vn_pkg::DIV_STEPS];
    logic [vn_pkg::LEN_W-1:0]  len  [0:vn_pkg::DIV_STEPS];
    rem_vec_t                  rem  [0:vn_pkg::DIV_STEPS];
    quo_vec_t                  quo  [0:vn_pkg::DIV_STEPS];

    assign v[0]    = in_valid;
    assign side[0] = in_side;
    assign len[0]  = in_len;
    assign quo[0]  = '0;
    for (genvar l = 0; l < vn_pkg::LANES; l++) begin : g_init
        assign rem[0][l] = {1'b0, in_side.mag[l]};
    end

    // restoring division, one quotient bit per stage for all three lanes;
    // magnitude never exceeds the length, so the first step needs no shift
    for (genvar k = 0; k < vn_pkg::DIV_STEPS; k++) begin : g_step
        logic                     v_reg;
        vn_pkg::side_t            side_reg;
        logic [vn_pkg::LEN_W-1:0] len_reg;
        rem_vec_t                 rem_reg, rem_next;
        quo_vec_t                 quo_reg, quo_next;

        always_comb begin
            logic [vn_pkg::REM_W-1:0] r2;
            for (int l = 0; l < vn_pkg::LANES; l++) begin
                r2 = (k == 0) ? rem[k][l] : (rem[k][l] << 1);
                if (r2 >= {1'b0, len[k]}) begin
                    rem_next[l] = r2 - {1'b0, len[k]};
                    quo_next[l] = {quo[k][l][vn_pkg::UNIT_W-2:0], 1'b1};
                end else begin
                    rem_next[l] = r2;
                    quo_next[l] = {quo[k][l][vn_pkg::UNIT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg <= side[k];
                len_reg  <= len[k];
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
            end
        end

        assign v[k+1]    = v_reg;
        assign side[k+1] = side_reg;
        assign len[k+1]  = len_reg;
        assign rem[k+1]  = rem_reg;
        assign quo[k+1]  = quo_reg;
    end

    // sign restore and zero-length override on the last stage
    logic                     zero;
    quo_vec_t                 unit;
    vn_pkg::side_t            last_side;
    logic [vn_pkg::LEN_W-1:0] last_len;

    assign last_side = side[vn_pkg::DIV_STEPS];
    assign last_len  = len[vn_pkg::DIV_STEPS];
    assign zero      = (last_len == '0);

    always_comb begin
        for (int l = 0; l < vn_pkg::LANES; l++) begin
            if (zero) begin
                unit[l] = '0;
            end else if (last_side.neg[l]) begin
                unit[l] = ~quo[vn_pkg::DIV_STEPS][l] + vn_pkg::UNIT_W'(1);
            end else begin
                unit[l] = quo[vn_pkg::DIV_STEPS][l];
            end
        end
    end

    assign out_valid           = v[vn_pkg::DIV_STEPS];
    assign out_item.unit_x     = unit[0];
    assign out_item.unit_y     = unit[1];
    assign out_item.unit_z     = unit[2];
    assign out_item.length_sq  = last_side.sq;
    assign out_item.length_val = last_len;
    assign out_item.zero_len   = zero;

endmodule

@@ src/vector3_normalize.sv @@
// vector3_normalize: takes one vector of three signed Q8.8 components per item
// and returns its squared length (Q16.16), its truncated length (Q8.8, integer
// square root) and the unit vector in Q2.14, each component divided by the
// length and truncated toward zero. The all-zero vector gives a zero unit
// vector with zero_len set. One item is accepted every clock while s_ready is
// high. There are 33 register stages: one for magnitudes and squares, one for
// the sum, 16 square root stages (one root bit each) and 15 divider stages
// (one quotient bit each, three lanes side by side). The whole pipeline
// advances together whenever the output register is empty or being taken, so
// s_ready follows m_ready while an item waits at the output.
module vector3_normalize (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vn_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vn_pkg::out_item_t m_data
);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: sign split and squares
    logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0] comp;
    logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0] mag;
    logic [vn_pkg::LANES-1:0]                     neg;

    assign comp[0] = s_data.vec_x;
    assign comp[1] = s_data.vec_y;
    assign comp[2] = s_data.vec_z;

    always_comb begin
        for (int l = 0; l < vn_pkg::LANES; l++) begin
            neg[l] = comp[l][vn_pkg::COMP_W-1];
            mag[l] = neg[l] ? (~comp[l] + vn_pkg::COMP_W'(1)) : comp[l];
        end
    end

    logic                                         s1_valid_reg;
    logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0] s1_mag_reg;
    logic [vn_pkg::LANES-1:0]                     s1_neg_reg;
    logic [vn_pkg::LANES-1:0][vn_pkg::SQ_W-1:0]   s1_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg <= mag;
            s1_neg_reg <= neg;
            for (int l = 0; l < vn_pkg::LANES; l++) begin
                s1_prod_reg[l] <= vn_pkg::SQ_W'(mag[l]) * vn_pkg::SQ_W'(mag[l]);
            end
        end
    end

    // stage 2: sum of squares; max is 3 * 2^30, fits 32 bits
    logic          s2_valid_reg;
    vn_pkg::side_t s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg.mag <= s1_mag_reg;
            s2_side_reg.neg <= s1_neg_reg;
            s2_side_reg.sq  <= s1_prod_reg[0] + s1_prod_reg[1] + s1_prod_reg[2];
        end
    end

    // square root
    logic                     rt_valid;
    vn_pkg::side_t            rt_side;
    logic [vn_pkg::LEN_W-1:0] rt_len;

    vn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .out_valid (rt_valid),
        .out_side  (rt_side),
        .out_len   (rt_len)
    );

    // per-component division; its last stage is the output register
    vn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt_valid),
        .in_side   (rt_side),
        .in_len    (rt_len),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

endmodule

@@ src/vn_checker.sv @@
module vn_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input vn_pkg::in_item_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input vn_pkg::out_item_t m_data
);

    logic [2*vn_pkg::LEN_W-1:0] len_sq;
    assign len_sq = m_data.length_val * m_data.length_val;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item dropped or changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_len |->
            m_data.unit_x == '0 && m_data.unit_y == '0 && m_data.unit_z == '0
            && m_data.length_val == '0 && m_data.length_sq == '0)
        else $error("zero-length item has nonzero fields");

    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> len_sq <= m_data.length_sq
            && (m_data.zero_len == (m_data.length_val == '0)))
        else $error("length is not the truncated root of length_sq");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Testbench for vector3_normalize.
// A driver pushes vectors from a pending queue, the predictor computes the
// expected normalized result at the moment each item is accepted, and the
// monitor compares every result taken from the block against the oldest
// expectation. The block holds no state, so ordering alone ties them together.
module testbench;

    localparam int LATENCY   = 33;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1200;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    vn_pkg::in_item_t  s_data;
    logic              m_valid;
    logic              m_ready;
    vn_pkg::out_item_t m_data;

    vn_pkg::in_item_t  pending_vecs[$];
    vn_pkg::out_item_t expected_units[$];
    int        error_count;
    int        idle_cycles;
    bit        calm_phase;   // no idling on either side near the end
    int        src_gap;
    int        sink_stall;

    vector3_normalize uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Integer square root, bit by bit, of a value up to 34 bits.
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Divide one component by the length in Q2.14, truncating toward zero.
    function automatic logic [vn_pkg::UNIT_W-1:0] scaled_unit(
            logic signed [vn_pkg::COMP_W-1:0] c, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        if (len == 0) return '0;
        mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
        q = (mag << vn_pkg::UNIT_FRAC) / len;
        if (c < 0) q = -q;
        return q[vn_pkg::UNIT_W-1:0];
    endfunction

    function automatic vn_pkg::out_item_t normalize_vec(vn_pkg::in_item_t v);
        vn_pkg::out_item_t r;
        longint signed   x, y, z;
        longint unsigned sq;
        longint unsigned len;
        x = v.vec_x;
        y = v.vec_y;
        z = v.vec_z;
        sq = x * x + y * y + z * z;
        len = root_floor(sq);
        r.unit_x     = scaled_unit(v.vec_x, len);
        r.unit_y     = scaled_unit(v.vec_y, len);
        r.unit_z     = scaled_unit(v.vec_z, len);
        r.length_sq  = sq[vn_pkg::SQ_W-1:0];
        r.length_val = len[vn_pkg::LEN_W-1:0];
        r.zero_len   = (len == 0);
        return r;
    endfunction

    function automatic logic [vn_pkg::COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;  // near zero
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: hold valid and payload until accepted, random source gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_units.push_back(normalize_vec(s_data));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_vecs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_vecs.pop_front();
                    if (!calm_phase && $urandom_range(0, 7) == 0)
                        src_gap <= $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result, random stall bursts on the sink.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    error_count++;
                end else begin
                    vn_pkg::out_item_t want;
                    want = expected_units.pop_front();
                    if (want.unit_x !== m_data.unit_x)
                        $display("%0t: unit_x expected %0d actual %0d",
                                 $time, want.unit_x, m_data.unit_x);
                    if (want.unit_y !== m_data.unit_y)
                        $display("%0t: unit_y expected %0d actual %0d",
                                 $time, want.unit_y, m_data.unit_y);
                    if (want.unit_z !== m_data.unit_z)
                        $display("%0t: unit_z expected %0d actual %0d",
                                 $time, want.unit_z, m_data.unit_z);
                    if (want.length_sq !== m_data.length_sq)
                        $display("%0t: length_sq expected %0d actual %0d",
                                 $time, want.length_sq, m_data.length_sq);
                    if (want.length_val !== m_data.length_val)
                        $display("%0t: length_val expected %0d actual %0d",
                                 $time, want.length_val, m_data.length_val);
                    if (want.zero_len !== m_data.zero_len)
                        $display("%0t: zero_len expected %0d actual %0d",
                                 $time, want.zero_len, m_data.zero_len);
                    if (want !== m_data) error_count++;
                end
            end
            if (sink_stall > 0) begin
                m_ready    <= 1'b0;
                sink_stall <= sink_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 7) == 0)
                    sink_stall <= $urandom_range(1, 10);
            end
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("vector3_normalize regression: fail");
            $finish;
        end
    end

    initial begin
        vn_pkg::in_item_t v;
        error_count = 0;
        idle_cycles = 0;
        calm_phase  = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        aresetn     = 1'b0;

        // directed: zero vector, extremes on each axis, mixed signs
        pending_vecs.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
        pending_vecs.push_back('{16'sh7fff, 16'sh0000, 16'sh0000});
        pending_vecs.push_back('{16'sh0000, 16'sh8000, 16'sh0000});
        pending_vecs.push_back('{16'sh0000, 16'sh0000, 16'sh8000});
        pending_vecs.push_back('{16'sh8000, 16'sh8000, 16'sh8000});  // largest length_sq
        pending_vecs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_vecs.push_back('{16'sh8000, 16'sh7fff, 16'sh8000});
        pending_vecs.push_back('{16'sh0001, 16'sh0000, 16'sh0000});
        pending_vecs.push_back('{16'shffff, 16'shffff, 16'shffff});
        pending_vecs.push_back('{16'sh0100, 16'sh0100, 16'sh0100});
        pending_vecs.push_back('{16'sh0300, 16'shfc00, 16'sh0000});  // 3-4-5
        pending_vecs.push_back('{16'sh0000, 16'sh0000, 16'shff00});
        pending_vecs.push_back('{16'sh5555, 16'shaaaa, 16'sh1234});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++) begin
            v.vec_x = rand_comp();
            v.vec_y = rand_comp();
            v.vec_z = rand_comp();
            pending_vecs.push_back(v);
        end

        wait (pending_vecs.size() < 150);
        @(posedge aclk);
        calm_phase = 1'b1;
        wait (pending_vecs.size() == 0 && !s_valid);
        wait (expected_units.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);

        if (error_count == 0)
            $display("vector3_normalize regression: pass");
        else
            $display("vector3_normalize regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
src/vn_pkg.sv
src/vn_sqrt.sv
src/vn_div.sv
src/vector3_normalize.sv
src/vn_checker.sv
tb/testbench.sv
